@@ sv/rtha_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package rtha_pkg;

    // sequencer states, one-hot
    typedef enum logic [10:0] {
        S_IDLE  = 11'b000_0000_0001,
        S_MUL   = 11'b000_0000_0010,
        S_DRAIN = 11'b000_0000_0100,
        S_NORM  = 11'b000_0000_1000,
        S_TEST1 = 11'b000_0001_0000,
        S_TEST2 = 11'b000_0010_0000,
        S_DIVI  = 11'b000_0100_0000,
        S_DIV   = 11'b000_1000_0000,
        S_TVAL  = 11'b001_0000_0000,
        S_UPD   = 11'b010_0000_0000,
        S_EMIT  = 11'b100_0000_0000
    } state_t;

    // config register indexes
    localparam logic [2:0] REG_ORG_X = 3'd0;
    localparam logic [2:0] REG_ORG_Y = 3'd1;
    localparam logic [2:0] REG_ORG_Z = 3'd2;
    localparam logic [2:0] REG_DIR_X = 3'd3;
    localparam logic [2:0] REG_DIR_Y = 3'd4;
    localparam logic [2:0] REG_DIR_Z = 3'd5;
    localparam logic [2:0] REG_SKIP  = 3'd6;
    localparam logic [2:0] REG_MDET  = 3'd7;

    localparam int CFG_BITS = 40;
    localparam int CNT_BITS = 24;
    localparam int T_BITS   = 32;
    localparam int QUO_BITS = 33;
    localparam int T_FRAC   = 16;

    localparam logic [CNT_BITS-1:0] CNT_MAX = '1;
    localparam logic [T_BITS-1:0]   T_MAX   = 32'h7FFF_FFFF;
    localparam logic [T_BITS-1:0]   T_MIN   = 32'h8000_0000;
    localparam logic [39:0]         MDET_RST = 40'd1;
    localparam logic [31:0]         DIRX_RST = 32'd4096;

    // short-vector operand codes
    localparam logic [3:0] N_D0 = 4'd0,  N_D1 = 4'd1,  N_D2 = 4'd2;
    localparam logic [3:0] N_E10 = 4'd3, N_E11 = 4'd4, N_E12 = 4'd5;
    localparam logic [3:0] N_E20 = 4'd6, N_E21 = 4'd7, N_E22 = 4'd8;
    localparam logic [3:0] N_S0 = 4'd9,  N_S1 = 4'd10, N_S2 = 4'd11;

    // destinations: 0..5 cross-product words p0..p2, q0..q2
    localparam logic [3:0] D_P0 = 4'd0, D_P1 = 4'd1, D_P2 = 4'd2;
    localparam logic [3:0] D_Q0 = 4'd3, D_Q1 = 4'd4, D_Q2 = 4'd5;
    localparam logic [3:0] D_DET = 4'd6, D_U = 4'd7, D_V = 4'd8, D_T = 4'd9;

    localparam int         N_STEPS   = 36;
    localparam logic [5:0] LAST_STEP = 6'd35;

    typedef struct packed {
        logic [3:0] a_sel;
        logic       b_wide;   // b from p/q word
        logic       b_hi;     // upper part of p/q word
        logic [3:0] b_sel;
        logic       neg;
        logic       first;
        logic       last;
        logic [3:0] dest;
    } uop_t;

    function automatic uop_t mk(input logic [3:0] a, input logic bw, input logic bh,
                                input logic [3:0] b, input logic ng, input logic fs,
                                input logic ls, input logic [3:0] d);
        uop_t u;
        u.a_sel = a; u.b_wide = bw; u.b_hi = bh; u.b_sel = b;
        u.neg = ng; u.first = fs; u.last = ls; u.dest = d;
        return u;
    endfunction

    // p = dir x e2, q = s x e1, then det = e1.p, U = s.p, V = dir.q, T = e2.q
    function automatic uop_t uop_at(input logic [5:0] st);
        uop_t u;
        case (st)
            6'd0:  u = mk(N_D1, 0, 0, N_E22, 0, 1, 0, D_P0);
            6'd1:  u = mk(N_D2, 0, 0, N_E21, 1, 0, 1, D_P0);
            6'd2:  u = mk(N_D2, 0, 0, N_E20, 0, 1, 0, D_P1);
            6'd3:  u = mk(N_D0, 0, 0, N_E22, 1, 0, 1, D_P1);
            6'd4:  u = mk(N_D0, 0, 0, N_E21, 0, 1, 0, D_P2);
            6'd5:  u = mk(N_D1, 0, 0, N_E20, 1, 0, 1, D_P2);
            6'd6:  u = mk(N_S1, 0, 0, N_E12, 0, 1, 0, D_Q0);
            6'd7:  u = mk(N_S2, 0, 0, N_E11, 1, 0, 1, D_Q0);
            6'd8:  u = mk(N_S2, 0, 0, N_E10, 0, 1, 0, D_Q1);
            6'd9:  u = mk(N_S0, 0, 0, N_E12, 1, 0, 1, D_Q1);
            6'd10: u = mk(N_S0, 0, 0, N_E11, 0, 1, 0, D_Q2);
            6'd11: u = mk(N_S1, 0, 0, N_E10, 1, 0, 1, D_Q2);
            6'd12: u = mk(N_E10, 1, 0, D_P0, 0, 1, 0, D_DET);
            6'd13: u = mk(N_E10, 1, 1, D_P0, 0, 0, 0, D_DET);
            6'd14: u = mk(N_E11, 1, 0, D_P1, 0, 0, 0, D_DET);
            6'd15: u = mk(N_E11, 1, 1, D_P1, 0, 0, 0, D_DET);
            6'd16: u = mk(N_E12, 1, 0, D_P2, 0, 0, 0, D_DET);
            6'd17: u = mk(N_E12, 1, 1, D_P2, 0, 0, 1, D_DET);
            6'd18: u = mk(N_S0, 1, 0, D_P0, 0, 1, 0, D_U);
            6'd19: u = mk(N_S0, 1, 1, D_P0, 0, 0, 0, D_U);
            6'd20: u = mk(N_S1, 1, 0, D_P1, 0, 0, 0, D_U);
            6'd21: u = mk(N_S1, 1, 1, D_P1, 0, 0, 0, D_U);
            6'd22: u = mk(N_S2, 1, 0, D_P2, 0, 0, 0, D_U);
            6'd23: u = mk(N_S2, 1, 1, D_P2, 0, 0, 1, D_U);
            6'd24: u = mk(N_D0, 1, 0, D_Q0, 0, 1, 0, D_V);
            6'd25: u = mk(N_D0, 1, 1, D_Q0, 0, 0, 0, D_V);
            6'd26: u = mk(N_D1, 1, 0, D_Q1, 0, 0, 0, D_V);
            6'd27: u = mk(N_D1, 1, 1, D_Q1, 0, 0, 0, D_V);
            6'd28: u = mk(N_D2, 1, 0, D_Q2, 0, 0, 0, D_V);
            6'd29: u = mk(N_D2, 1, 1, D_Q2, 0, 0, 1, D_V);
            6'd30: u = mk(N_E20, 1, 0, D_Q0, 0, 1, 0, D_T);
            6'd31: u = mk(N_E20, 1, 1, D_Q0, 0, 0, 0, D_T);
            6'd32: u = mk(N_E21, 1, 0, D_Q1, 0, 0, 0, D_T);
            6'd33: u = mk(N_E21, 1, 1, D_Q1, 0, 0, 0, D_T);
            6'd34: u = mk(N_E22, 1, 0, D_Q2, 0, 0, 0, D_T);
            6'd35: u = mk(N_E22, 1, 1, D_Q2, 0, 0, 1, D_T);
            default: u = mk(N_D0, 0, 0, N_D0, 0, 1, 0, D_DET);
        endcase
        return u;
    endfunction

endpackage

`default_nettype wire

@@ sv/ray_triangle_hit_accumulator_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none

// channel   | dir | handshake                 | content
// s_*       | in  | s_tvalid/s_tready, tlast  | one triangle word, tlast = last_tri
// m_*       | out | m_tvalid/m_tready         | batch result word
// cfg_*     | in  | cfg_we                    | register write, index + data
//
// Sequence per triangle that reaches the divider: accept, multiply issues plus a
// drain on the shared multiplier, normalise and test, divider setup, divider
// steps, t select, update; a rejected one skips to the update. The single shared
// multiplier/accumulator and radix-2 divider set this; a last word adds emit.
// Reset: async, active low; config back to defaults, batch cleared.
// Stalls: a result waits in the output register while the next triangle runs;
// only a second last word stalls, in the emit state, until m_tready.
module ray_triangle_hit_accumulator_unit
    import rtha_pkg::*;
#(
    parameter int COORD_BITS = 24,
    parameter int ID_BITS    = 24
)
(
    input  wire  clk,
    input  wire  rst_n,
    input  wire  s_tvalid,
    output logic s_tready,
    // ax, ay, az, bx, by_coord, bz, cx, cy, cz, tri_id (lowest first)
    input  wire  [((9*COORD_BITS+ID_BITS+7)/8)*8-1:0] s_tdata,
    input  wire  s_tlast,
    output logic m_tvalid,
    input  wire  m_tready,
    // hit_count, found, nearest_t, nearest_id (lowest first)
    output logic [((57+ID_BITS+7)/8)*8-1:0] m_tdata,
    input  wire  cfg_we,
    input  wire  [2:0] cfg_index,
    input  wire  [CFG_BITS-1:0] cfg_data
);

    localparam int C   = COORD_BITS;
    localparam int NW  = C + 1;          // edge / offset vectors
    localparam int WW  = 2*C + 3;        // cross-product words
    localparam int MW  = C + 3;          // multiplier operands
    localparam int PW  = 2*MW;
    localparam int ACC = 3*C + 8;        // dot products
    localparam int NUMW = ACC + T_FRAC;
    localparam int OW  = ((57+ID_BITS+7)/8)*8;

    // configuration
    logic signed [C-1:0] org_reg [3];
    logic signed [C-1:0] dcfg_reg [3];
    logic signed [31:0]  skip_reg;
    logic [39:0]         mdet_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            org_reg[0]  <= '0;
            org_reg[1]  <= '0;
            org_reg[2]  <= '0;
            dcfg_reg[0] <= DIRX_RST[C-1:0];
            dcfg_reg[1] <= '0;
            dcfg_reg[2] <= '0;
            skip_reg    <= '0;
            mdet_reg    <= MDET_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ORG_X: org_reg[0]  <= cfg_data[C-1:0];
                REG_ORG_Y: org_reg[1]  <= cfg_data[C-1:0];
                REG_ORG_Z: org_reg[2]  <= cfg_data[C-1:0];
                REG_DIR_X: dcfg_reg[0] <= cfg_data[C-1:0];
                REG_DIR_Y: dcfg_reg[1] <= cfg_data[C-1:0];
                REG_DIR_Z: dcfg_reg[2] <= cfg_data[C-1:0];
                REG_SKIP:  skip_reg    <= cfg_data[31:0];
                REG_MDET:  mdet_reg    <= cfg_data;
                default:   mdet_reg    <= mdet_reg;
            endcase
        end
    end

    // input unpack
    logic signed [C-1:0] va [3];
    logic signed [C-1:0] vb [3];
    logic signed [C-1:0] vc [3];
    logic [ID_BITS-1:0]  in_id;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            va[k] = s_tdata[k*C +: C];
            vb[k] = s_tdata[(3+k)*C +: C];
            vc[k] = s_tdata[(6+k)*C +: C];
        end
        in_id = s_tdata[9*C +: ID_BITS];
    end

    // control
    state_t state_reg, state_next;
    logic [5:0] step_reg, step_next;
    logic       pv_reg;
    logic [5:0] dcnt_reg, dcnt_next;
    logic       hit_reg, hit_next;
    logic       last_reg;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic signed [T_BITS-1:0] best_t_reg, best_t_next;
    logic [ID_BITS-1:0]  best_id_reg, best_id_next;
    logic       any_reg, any_next;
    logic       ov_reg, ov_next;

    // datapath
    logic signed [NW-1:0] dir_reg [3];
    logic signed [NW-1:0] e1_reg [3];
    logic signed [NW-1:0] e2_reg [3];
    logic signed [NW-1:0] s_reg [3];
    logic signed [WW-1:0] pq_reg [6];
    logic signed [ACC-1:0] acc_reg, det_reg, u_reg, v_reg, t_reg;
    logic signed [PW-1:0] prod_reg;
    uop_t                 puop_reg;
    logic [ID_BITS-1:0]   id_reg;
    logic                 tneg_reg, ovf_reg;
    logic [NUMW-1:0]      num_reg;
    logic [ACC:0]         rem_reg;
    logic [QUO_BITS-1:0]  quo_reg;
    logic signed [T_BITS-1:0] tq_reg;
    logic [CNT_BITS-1:0]  o_cnt_reg;
    logic                 o_found_reg;
    logic signed [T_BITS-1:0] o_t_reg;
    logic [ID_BITS-1:0]   o_id_reg;

    uop_t                 uop;
    logic signed [NW-1:0] a_nv, b_nv;
    logic signed [WW-1:0] b_w;
    logic signed [MW-1:0] a_op, b_op;
    logic signed [ACC-1:0] term, acc_next;
    logic signed [ACC-1:0] sum_uv;
    logic [ACC:0]         rem2;
    logic                 rem_ge;
    logic [NUMW-1:0]      num_init;
    logic signed [T_BITS-1:0] tq_sel;
    logic                 out_free;

    assign uop = uop_at(step_reg);

    function automatic logic signed [NW-1:0] nsel(
        input logic [3:0] sel,
        input logic signed [NW-1:0] d0, input logic signed [NW-1:0] d1,
        input logic signed [NW-1:0] d2, input logic signed [NW-1:0] f0,
        input logic signed [NW-1:0] f1, input logic signed [NW-1:0] f2,
        input logic signed [NW-1:0] g0, input logic signed [NW-1:0] g1,
        input logic signed [NW-1:0] g2, input logic signed [NW-1:0] h0,
        input logic signed [NW-1:0] h1, input logic signed [NW-1:0] h2);
        logic signed [NW-1:0] r;
        case (sel)
            N_D0:  r = d0;
            N_D1:  r = d1;
            N_D2:  r = d2;
            N_E10: r = f0;
            N_E11: r = f1;
            N_E12: r = f2;
            N_E20: r = g0;
            N_E21: r = g1;
            N_E22: r = g2;
            N_S0:  r = h0;
            N_S1:  r = h1;
            N_S2:  r = h2;
            default: r = '0;
        endcase
        return r;
    endfunction

    always_comb
    begin
        a_nv = nsel(uop.a_sel, dir_reg[0], dir_reg[1], dir_reg[2], e1_reg[0], e1_reg[1],
                    e1_reg[2], e2_reg[0], e2_reg[1], e2_reg[2], s_reg[0], s_reg[1], s_reg[2]);
        b_nv = nsel(uop.b_sel, dir_reg[0], dir_reg[1], dir_reg[2], e1_reg[0], e1_reg[1],
                    e1_reg[2], e2_reg[0], e2_reg[1], e2_reg[2], s_reg[0], s_reg[1], s_reg[2]);
        case (uop.b_sel)
            D_P0:    b_w = pq_reg[0];
            D_P1:    b_w = pq_reg[1];
            D_P2:    b_w = pq_reg[2];
            D_Q0:    b_w = pq_reg[3];
            D_Q1:    b_w = pq_reg[4];
            D_Q2:    b_w = pq_reg[5];
            default: b_w = '0;
        endcase
        a_op = {{2{a_nv[NW-1]}}, a_nv};
        if (!uop.b_wide)
            b_op = {{2{b_nv[NW-1]}}, b_nv};
        else if (uop.b_hi)
            b_op = {b_w[WW-1], b_w[WW-1:C+1]};
        else
            b_op = {2'b00, b_w[C:0]};
    end

    // accumulate the product issued last cycle; upper parts weigh 2^(C+1)
    always_comb
    begin
        term = {{(ACC-PW){prod_reg[PW-1]}}, prod_reg};
        if (puop_reg.b_hi)
            term = term <<< (C+1);
        if (puop_reg.neg)
            term = -term;
        acc_next = (puop_reg.first ? '0 : acc_reg) + term;
    end

    assign sum_uv   = u_reg + v_reg;
    assign rem2     = {rem_reg[ACC-1:0], num_reg[QUO_BITS-1]};
    assign rem_ge   = rem2 >= {1'b0, det_reg};
    assign num_init = {(tneg_reg ? -t_reg : t_reg), {T_FRAC{1'b0}}};
    assign out_free = !ov_reg || m_tready;

    // truncated quotient, saturated to 32 bits signed
    always_comb
    begin
        if (!tneg_reg)
            tq_sel = (ovf_reg || quo_reg > {1'b0, T_MAX}) ? T_MAX : quo_reg[T_BITS-1:0];
        else
            tq_sel = (ovf_reg || quo_reg > {1'b0, T_MIN}) ? T_MIN : -quo_reg[T_BITS-1:0];
    end

    always_comb
    begin
        state_next   = state_reg;
        step_next    = step_reg;
        dcnt_next    = dcnt_reg;
        hit_next     = hit_reg;
        cnt_next     = cnt_reg;
        best_t_next  = best_t_reg;
        best_id_next = best_id_reg;
        any_next     = any_reg;
        ov_next      = ov_reg;
        if (ov_reg && m_tready)
            ov_next = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = S_MUL;
                    step_next  = '0;
                end
            end
            S_MUL:
            begin
                step_next = step_reg + 6'd1;
                if (step_reg == LAST_STEP)
                    state_next = S_DRAIN;
            end
            S_DRAIN: state_next = S_NORM;
            S_NORM:  state_next = S_TEST1;
            S_TEST1:
            begin
                // zero determinant always counts as parallel
                hit_next = !(det_reg == '0 || det_reg < $signed({1'b0, mdet_reg})
                             || u_reg < 0 || det_reg < u_reg);
                state_next = hit_next ? S_TEST2 : S_UPD;
            end
            S_TEST2:
            begin
                hit_next = !(v_reg < 0 || det_reg < v_reg || det_reg < sum_uv);
                state_next = hit_next ? S_DIVI : S_UPD;
            end
            S_DIVI:
            begin
                dcnt_next  = 6'(QUO_BITS - 1);
                state_next = S_DIV;
            end
            S_DIV:
            begin
                dcnt_next = dcnt_reg - 6'd1;
                if (ovf_reg || dcnt_reg == '0)
                    state_next = S_TVAL;
            end
            S_TVAL:
            begin
                hit_next   = tq_sel >= skip_reg;
                state_next = S_UPD;
            end
            S_UPD:
            begin
                if (hit_reg)
                begin
                    if (cnt_reg != CNT_MAX)
                        cnt_next = cnt_reg + 1'b1;
                    if (!any_reg || tq_reg < best_t_reg)
                    begin
                        best_t_next  = tq_reg;
                        best_id_next = id_reg;
                        any_next     = 1'b1;
                    end
                end
                state_next = last_reg ? S_EMIT : S_IDLE;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    ov_next      = 1'b1;
                    cnt_next     = '0;
                    best_t_next  = T_MAX;
                    best_id_next = '0;
                    any_next     = 1'b0;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            step_reg    <= '0;
            pv_reg      <= 1'b0;
            dcnt_reg    <= '0;
            hit_reg     <= 1'b0;
            cnt_reg     <= '0;
            best_t_reg  <= T_MAX;
            best_id_reg <= '0;
            any_reg     <= 1'b0;
            ov_reg      <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            pv_reg      <= (state_reg == S_MUL);
            dcnt_reg    <= dcnt_next;
            hit_reg     <= hit_next;
            cnt_reg     <= cnt_next;
            best_t_reg  <= best_t_next;
            best_id_reg <= best_id_next;
            any_reg     <= any_next;
            ov_reg      <= ov_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && s_tvalid)
        begin
            for (int k = 0; k < 3; k++)
            begin
                dir_reg[k] <= {dcfg_reg[k][C-1], dcfg_reg[k]};
                e1_reg[k]  <= {vb[k][C-1], vb[k]} - {va[k][C-1], va[k]};
                e2_reg[k]  <= {vc[k][C-1], vc[k]} - {va[k][C-1], va[k]};
                s_reg[k]   <= {org_reg[k][C-1], org_reg[k]} - {va[k][C-1], va[k]};
            end
            id_reg   <= in_id;
            last_reg <= s_tlast;
        end
        if (state_reg == S_MUL)
        begin
            prod_reg <= a_op * b_op;
            puop_reg <= uop;
        end
        if (pv_reg)
        begin
            acc_reg <= acc_next;
            if (puop_reg.last)
            begin
                case (puop_reg.dest)
                    D_P0:  pq_reg[0] <= acc_next[WW-1:0];
                    D_P1:  pq_reg[1] <= acc_next[WW-1:0];
                    D_P2:  pq_reg[2] <= acc_next[WW-1:0];
                    D_Q0:  pq_reg[3] <= acc_next[WW-1:0];
                    D_Q1:  pq_reg[4] <= acc_next[WW-1:0];
                    D_Q2:  pq_reg[5] <= acc_next[WW-1:0];
                    D_DET: det_reg   <= acc_next;
                    D_U:   u_reg     <= acc_next;
                    D_V:   v_reg     <= acc_next;
                    D_T:   t_reg     <= acc_next;
                    default: ;
                endcase
            end
        end
        if (state_reg == S_NORM)
        begin
            tneg_reg <= t_reg[ACC-1] ^ det_reg[ACC-1];
            if (det_reg < 0)
            begin
                det_reg <= -det_reg;
                u_reg   <= -u_reg;
                v_reg   <= -v_reg;
                t_reg   <= -t_reg;
            end
        end
        if (state_reg == S_TEST1)
            tneg_reg <= t_reg[ACC-1];
        if (state_reg == S_DIVI)
        begin
            num_reg <= num_init;
            rem_reg <= {{(ACC+1-NUMW+QUO_BITS){1'b0}}, num_init[NUMW-1:QUO_BITS]};
            ovf_reg <= num_init[NUMW-1:QUO_BITS] >= det_reg[ACC-2:0];
            quo_reg <= '0;
        end
        if (state_reg == S_DIV)
        begin
            num_reg <= num_reg << 1;
            quo_reg <= {quo_reg[QUO_BITS-2:0], rem_ge};
            rem_reg <= rem_ge ? rem2 - {1'b0, det_reg} : rem2;
        end
        if (state_reg == S_TVAL)
            tq_reg <= tq_sel;
        if (state_reg == S_EMIT && out_free)
        begin
            o_cnt_reg   <= cnt_reg;
            o_found_reg <= any_reg;
            o_t_reg     <= best_t_reg;
            o_id_reg    <= any_reg ? best_id_reg : '0;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = ov_reg;
    assign m_tdata  = {{(OW-57-ID_BITS){1'b0}}, o_id_reg, o_t_reg, o_found_reg, o_cnt_reg};

    // checks
    a_cnt_any: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg != '0) == any_reg)
        else $error("hit count and found flag disagree");
    a_none_max: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && !o_found_reg) |-> (o_t_reg == T_MAX && o_cnt_reg == '0))
        else $error("empty batch result not at maximum t");
    a_acc_src: assert property (@(posedge clk) disable iff (!rst_n)
        pv_reg |-> $past(state_reg == S_MUL))
        else $error("accumulate without a multiply issue");
    a_emit_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT && !out_free) |=> (state_reg == S_EMIT && $stable(cnt_reg)))
        else $error("batch state lost while result blocked");

endmodule

`default_nettype wire
